FILE: hw/rtl/vaft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vaft_pkg;

    localparam int COORD_W  = 32;
    localparam int ANGLE_W  = 16;
    localparam int BAND_W   = 16;
    localparam int MAG_W    = 32;
    // the larger normalized magnitude keeps its leading one at this bit
    localparam int NORM_MSB = 45;
    localparam int NORM_W   = NORM_MSB + 1;
    // cordic x/y: gain and the diagonal stay below 2^48, plus sign
    localparam int XW       = 49;
    // angle accumulator: signed turns scaled by 2^Z_FRAC
    localparam int Z_FRAC   = 32;
    localparam int ZW       = Z_FRAC + 1;
    localparam int TAB_SIZE = 24;

    // atan(2^-i) / (2*pi) * 2^32, rounded to nearest
    localparam logic [31:0] ATAN_TAB [TAB_SIZE] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] vec_x;
        logic signed [COORD_W-1:0] vec_y;
    } vec_item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               zero_vector;
    } res_item_t;

    typedef struct packed {
        logic sx;
        logic sy;
        logic zx;
        logic zy;
    } flags_t;

    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        flags_t           fl;
    } front_t;

    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic [4:0]       lz;
        flags_t           fl;
    } lzc_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        flags_t               fl;
    } cordic_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vector_angle_full_turn.sv
`timescale 1ns / 1ps
`default_nettype none

// Vector angle as a fraction of a full turn (65536 = one turn), counter-clockwise from +x.
// Fully pipelined: one item per cycle while res_stall is low. The stages are abs and zero-band
// check, leading-zero count, normalizing shift, one unrolled CORDIC stage per iteration,
// and the output register with quadrant mapping. Bubbles collapse when res_stall is high,
// so input keeps being taken until every stage holds an item. Components with magnitude at
// or below zero_band (written through the cfg port, reset 0) count as zero; a zero vector
// gives angle 0 with zero_vector set, and on-axis vectors give exact quarter turns.
module vector_angle_full_turn #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       vec_valid,
    output logic                       vec_stall,
    input  vaft_pkg::vec_item_t        vec_data,
    output logic                       res_valid,
    input  logic                       res_stall,
    output vaft_pkg::res_item_t        res_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [vaft_pkg::BAND_W-1:0] cfg_data
);
    import vaft_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS > TAB_SIZE) ? TAB_SIZE : CORDIC_STEPS;
    localparam int NS     = NSTEPS + 4;
    localparam int ZC_W   = Z_FRAC - 1;
    localparam logic [ZC_W-1:0] Z_QUARTER = ZC_W'(1) << (Z_FRAC - 2);
    localparam logic [ZC_W-1:0] Z_HALF_LSB = ZC_W'(1) << (Z_FRAC - ANGLE_W - 1);
    localparam logic [ANGLE_W-1:0] A_QUARTER = ANGLE_W'(1) << (ANGLE_W - 2);
    localparam logic [ANGLE_W-1:0] A_HALF    = ANGLE_W'(1) << (ANGLE_W - 1);
    localparam logic [5:0] NORM_BASE = 6'(NORM_MSB - (MAG_W - 1));

    function automatic logic [4:0] clz32(input logic [MAG_W-1:0] v);
        logic [MAG_W-1:0] w;
        logic [4:0]       n;
        w = v;
        n = '0;
        if (w[31:16] == '0)
        begin
            n[4] = 1'b1;
            w = w << 16;
        end
        if (w[31:24] == '0)
        begin
            n[3] = 1'b1;
            w = w << 8;
        end
        if (w[31:28] == '0)
        begin
            n[2] = 1'b1;
            w = w << 4;
        end
        if (w[31:30] == '0)
        begin
            n[1] = 1'b1;
            w = w << 2;
        end
        if (!w[31])
        begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

    logic [BAND_W-1:0] zero_band_reg;
    logic [NS-1:0]     vld_reg;
    logic [NS-1:0]     vld_next;
    logic [NS:0]       rdy;

    front_t    front_reg, front_next;
    lzc_t      lzc_reg, lzc_next;
    cordic_t   cr_reg  [NSTEPS+1];
    cordic_t   cr_next [NSTEPS+1];
    res_item_t out_reg, out_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_band_reg <= '0;
        end
        else if (cfg_valid)
        begin
            zero_band_reg <= cfg_data;
        end
    end

    // a stage loads when it is empty or its successor moves on
    assign rdy[NS] = !res_stall;

    for (genvar k = 0; k < NS; k++)
    begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    assign vec_stall = !rdy[0];
    assign res_valid = vld_reg[NS-1];
    assign res_data  = out_reg;

    always_comb
    begin
        logic [NS-1:0] up;
        up = {vld_reg[NS-2:0], vec_valid};
        vld_next = vld_reg;
        for (int k = 0; k < NS; k++)
        begin
            if (rdy[k])
            begin
                vld_next[k] = up[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // magnitudes and zero band
    always_comb
    begin
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        ax = vec_data.vec_x[COORD_W-1] ? MAG_W'(-vec_data.vec_x) : MAG_W'(vec_data.vec_x);
        ay = vec_data.vec_y[COORD_W-1] ? MAG_W'(-vec_data.vec_y) : MAG_W'(vec_data.vec_y);
        front_next.ax    = ax;
        front_next.ay    = ay;
        front_next.fl.sx = vec_data.vec_x[COORD_W-1];
        front_next.fl.sy = vec_data.vec_y[COORD_W-1];
        front_next.fl.zx = ax <= MAG_W'(zero_band_reg);
        front_next.fl.zy = ay <= MAG_W'(zero_band_reg);
    end

    // leading zeros of the larger magnitude
    always_comb
    begin
        logic [MAG_W-1:0] big;
        big = (front_reg.ax > front_reg.ay) ? front_reg.ax : front_reg.ay;
        lzc_next.ax = front_reg.ax;
        lzc_next.ay = front_reg.ay;
        lzc_next.lz = clz32(big);
        lzc_next.fl = front_reg.fl;
    end

    // normalize so the larger magnitude has its top bit at NORM_MSB
    always_comb
    begin
        logic [5:0]        shamt;
        logic [NORM_W-1:0] xn;
        logic [NORM_W-1:0] yn;
        shamt = 6'(lzc_reg.lz) + NORM_BASE;
        xn = NORM_W'(lzc_reg.ax) << shamt;
        yn = NORM_W'(lzc_reg.ay) << shamt;
        cr_next[0].x  = XW'(xn);
        cr_next[0].y  = XW'(yn);
        cr_next[0].z  = '0;
        cr_next[0].fl = lzc_reg.fl;
    end

    // unrolled vectoring cordic, one iteration per stage
    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_cordic
        always_comb
        begin
            logic signed [XW-1:0] dx;
            logic signed [XW-1:0] dy;
            logic [ZW-1:0]        dz;
            dx = $signed(cr_reg[i].y) >>> i;
            dy = $signed(cr_reg[i].x) >>> i;
            dz = ZW'(ATAN_TAB[i]);
            cr_next[i+1].fl = cr_reg[i].fl;
            if (!cr_reg[i].y[XW-1])
            begin
                cr_next[i+1].x = cr_reg[i].x + dx;
                cr_next[i+1].y = cr_reg[i].y - dy;
                cr_next[i+1].z = ZW'(cr_reg[i].z + dz);
            end
            else
            begin
                cr_next[i+1].x = cr_reg[i].x - dx;
                cr_next[i+1].y = cr_reg[i].y + dy;
                cr_next[i+1].z = ZW'(cr_reg[i].z - dz);
            end
        end
    end

    // clamp, round and map to the vector's quadrant
    always_comb
    begin
        logic [ZW-1:0]      z;
        logic [ZC_W-1:0]    zc;
        logic [ZC_W-1:0]    zr;
        logic [ANGLE_W-1:0] t;
        flags_t             fl;
        z  = cr_reg[NSTEPS].z;
        fl = cr_reg[NSTEPS].fl;
        if (z[ZW-1])
        begin
            zc = '0;
        end
        else if (z[ZW-2:0] > (ZW-1)'(Z_QUARTER))
        begin
            zc = Z_QUARTER;
        end
        else
        begin
            zc = z[ZC_W-1:0];
        end
        zr = (zc + Z_HALF_LSB) >> (Z_FRAC - ANGLE_W);
        t  = zr[ANGLE_W-1:0];

        out_next.zero_vector = 1'b0;
        if (fl.zx && fl.zy)
        begin
            out_next.angle       = '0;
            out_next.zero_vector = 1'b1;
        end
        else if (fl.zx)
        begin
            out_next.angle = fl.sy ? ANGLE_W'(A_QUARTER + A_HALF) : A_QUARTER;
        end
        else if (fl.zy)
        begin
            out_next.angle = fl.sx ? A_HALF : '0;
        end
        else
        begin
            case ({fl.sx, fl.sy})
                2'b00:   out_next.angle = t;
                2'b01:   out_next.angle = ANGLE_W'(-t);
                2'b10:   out_next.angle = ANGLE_W'(A_HALF - t);
                default: out_next.angle = ANGLE_W'(A_HALF + t);
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            front_reg <= front_next;
        end
        if (rdy[1])
        begin
            lzc_reg <= lzc_next;
        end
        for (int j = 0; j <= NSTEPS; j++)
        begin
            if (rdy[j+2])
            begin
                cr_reg[j] <= cr_next[j];
            end
        end
        if (rdy[NS-1])
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/vaft_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module vaft_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                vec_stall,
    input logic                res_valid,
    input logic                res_stall,
    input vaft_pkg::res_item_t res_data
);

    // a zero vector always reports angle zero
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.zero_vector |-> res_data.angle == '0)
        else $error("zero vector with nonzero angle");

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // with the output draining, every stage moves, so input is never held off
    a_no_backpressure: assert property (@(posedge clk)
        !res_stall |-> !vec_stall)
        else $error("input stalled while output drains");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");

endmodule

bind vector_angle_full_turn vaft_checker u_vaft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .vec_stall (vec_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

`default_nettype wire
